>>> design/nearest_barcode_hamming_match_unit_assert.svh
// Assertion macros for the barcode matcher.
`ifndef NEAREST_BARCODE_HAMMING_MATCH_UNIT_ASSERT_SVH
`define NEAREST_BARCODE_HAMMING_MATCH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define NBHM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NBHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NBHM_ASSERT_IMPL(lbl, ante, cons, msg)
`define NBHM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/nbhm_pkg.sv
package nbhm_pkg;

  localparam int BARCODE_SLOTS_DEF = 16;
  localparam int BARCODE_MAX_LEN_DEF = 16;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIFFS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_MATCH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BARCODE_COUNT = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } nbhm_state_t;

  typedef struct packed {
    logic       en;
    logic       last;
    logic [3:0] slot;
    logic [3:0] position;
    logic [7:0] symbol;
  } nbhm_load_t;

  function automatic logic [7:0] up_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

>>> design/nbhm_symbol_store.sv
module nbhm_symbol_store #(
  parameter int BARCODE_SLOTS = nbhm_pkg::BARCODE_SLOTS_DEF,
  parameter int BARCODE_MAX_LEN = nbhm_pkg::BARCODE_MAX_LEN_DEF,
  localparam int SLOT_W = (BARCODE_SLOTS > 1) ? $clog2(BARCODE_SLOTS) : 1,
  localparam int LEN_W = (BARCODE_MAX_LEN > 1) ? $clog2(BARCODE_MAX_LEN) : 1
) (
  input  logic                 clk,
  input  nbhm_pkg::nbhm_load_t load,
  input  logic [SLOT_W-1:0]    rd_slot,
  input  logic [LEN_W-1:0]     rd_pos,
  output logic [7:0]           rd_symbol
);
  import nbhm_pkg::*;

  localparam int DEPTH = 2 ** (SLOT_W + LEN_W);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (load.en) begin
      mem[{SLOT_W'(load.slot), LEN_W'(load.position)}] <= load.symbol;
    end
    rdata <= mem[{rd_slot, rd_pos}];
  end

  assign rd_symbol = up_case(rdata);

endmodule

>>> design/nbhm_slot_store.sv
module nbhm_slot_store #(
  parameter int BARCODE_SLOTS = nbhm_pkg::BARCODE_SLOTS_DEF,
  parameter int BARCODE_MAX_LEN = nbhm_pkg::BARCODE_MAX_LEN_DEF,
  localparam int SLOT_W = (BARCODE_SLOTS > 1) ? $clog2(BARCODE_SLOTS) : 1,
  localparam int LENV_W = $clog2(BARCODE_MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  nbhm_pkg::nbhm_load_t      load,
  input  logic [SLOT_W-1:0]         rd_addr,
  output logic [LENV_W-1:0]         rd_len,
  output logic [nbhm_pkg::CNT_W-1:0] rd_cnt,
  input  logic                      wb_en,
  input  logic [SLOT_W-1:0]         wb_addr,
  input  logic [LENV_W-1:0]         wb_len,
  input  logic [nbhm_pkg::CNT_W-1:0] wb_cnt,
  input  logic                      clear_counts
);
  import nbhm_pkg::*;

  localparam int WORD_W = LENV_W + CNT_W;

  logic [WORD_W-1:0]        mem [BARCODE_SLOTS];
  logic [BARCODE_SLOTS-1:0] len_valid;
  logic [BARCODE_SLOTS-1:0] cnt_valid;
  logic [SLOT_W-1:0]        raddr;
  logic [SLOT_W-1:0]        waddr;
  logic                     we;
  logic [WORD_W-1:0]        wdata;
  logic [WORD_W-1:0]        rdata;
  logic                     rd_lv;
  logic                     rd_cv;
  logic                     ld_pend;
  logic [SLOT_W-1:0]        ld_addr;
  logic [LENV_W-1:0]        ld_len;

  assign raddr = load.en ? SLOT_W'(load.slot) : rd_addr;
  assign rd_len = rd_lv ? rdata[WORD_W-1:CNT_W] : '0;
  assign rd_cnt = rd_cv ? rdata[CNT_W-1:0] : '0;

  // A length load keeps the slot's running count, so it reads the word first.
  assign we = ld_pend || wb_en;
  assign waddr = ld_pend ? ld_addr : wb_addr;
  assign wdata = ld_pend ? {ld_len, rd_cnt} : {wb_len, wb_cnt};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
    ld_addr <= SLOT_W'(load.slot);
    ld_len <= LENV_W'({1'b0, load.position} + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_pend <= 1'b0;
      len_valid <= '0;
      cnt_valid <= '0;
      rd_lv <= 1'b0;
      rd_cv <= 1'b0;
    end else begin
      ld_pend <= load.en && load.last;
      rd_lv <= len_valid[raddr];
      rd_cv <= cnt_valid[raddr];
      if (ld_pend) begin
        len_valid[ld_addr] <= 1'b1;
      end
      if (clear_counts) begin
        cnt_valid <= '0;
      end else if (wb_en) begin
        cnt_valid[wb_addr] <= 1'b1;
      end
    end
  end

endmodule

>>> design/nearest_barcode_hamming_match_unit.sv
// Nearest barcode matcher by Hamming distance. A load item (command 0) writes one barcode
// character and, when last is set, the slot's length. A read item (command 1) sweeps the
// slots one per cycle through the single read ports of the symbol memory and the slot
// memory, which holds each slot's length and mismatch count, then the last count is written
// back and the item retires. A read item with last set yields one result with the eligible
// slot of fewest mismatches, lowest slot on ties. No clearing pass is needed after reset.
`include "nearest_barcode_hamming_match_unit_assert.svh"

module nearest_barcode_hamming_match_unit #(
  parameter int BARCODE_SLOTS = nbhm_pkg::BARCODE_SLOTS_DEF,
  parameter int BARCODE_MAX_LEN = nbhm_pkg::BARCODE_MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nbhm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nbhm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [7:0]                       symbol,
  input  logic [3:0]                       slot,
  input  logic [3:0]                       position,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       best_slot,
  output logic [4:0]                       min_diffs,
  output logic                             found,
  output logic                             assigned
);
  import nbhm_pkg::*;

  localparam int SLOT_W = (BARCODE_SLOTS > 1) ? $clog2(BARCODE_SLOTS) : 1;
  localparam int LEN_W = (BARCODE_MAX_LEN > 1) ? $clog2(BARCODE_MAX_LEN) : 1;
  localparam int LENV_W = $clog2(BARCODE_MAX_LEN + 1);
  localparam int RL_W = $clog2(BARCODE_MAX_LEN + 2);
  localparam logic [SLOT_W-1:0] LAST_B = SLOT_W'(BARCODE_SLOTS - 1);
  localparam logic [RL_W-1:0] RL_SAT = RL_W'(BARCODE_MAX_LEN + 1);

  nbhm_state_t       state;
  logic [4:0]        max_diffs;
  logic              prefix_match;
  logic [4:0]        barcode_count;
  logic [RL_W-1:0]   read_length;
  logic [RL_W-1:0]   ql;
  logic [7:0]        usym;
  logic              last_q;
  logic [SLOT_W-1:0] sweep_b;
  logic              s1_valid;
  logic [SLOT_W-1:0] s1_b;
  logic              found_acc;
  logic [SLOT_W-1:0] best;
  logic [CNT_W-1:0]  bestd;
  logic              in_acc;
  logic              in_range;
  nbhm_load_t        load;
  logic [7:0]        rd_symbol;
  logic [LENV_W-1:0] rd_len;
  logic [CNT_W-1:0]  rd_cnt;
  logic [RL_W-1:0]   len_ext;
  logic [CNT_W-1:0]  new_cnt;
  logic              eligible;
  logic              take;
  logic              out_free;
  logic              result_load;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign in_range = (9'(slot) < 9'(BARCODE_SLOTS)) && (7'(position) < 7'(BARCODE_MAX_LEN));

  assign load.en = in_acc && (command == CMD_LOAD) && in_range;
  assign load.last = last;
  assign load.slot = slot;
  assign load.position = position;
  assign load.symbol = symbol;

  nbhm_symbol_store #(
    .BARCODE_SLOTS(BARCODE_SLOTS),
    .BARCODE_MAX_LEN(BARCODE_MAX_LEN)
  ) u_symbols (
    .clk(clk),
    .load(load),
    .rd_slot(sweep_b),
    .rd_pos(LEN_W'(read_length)),
    .rd_symbol(rd_symbol)
  );

  nbhm_slot_store #(
    .BARCODE_SLOTS(BARCODE_SLOTS),
    .BARCODE_MAX_LEN(BARCODE_MAX_LEN)
  ) u_slots (
    .clk(clk),
    .rst(rst),
    .load(load),
    .rd_addr(sweep_b),
    .rd_len(rd_len),
    .rd_cnt(rd_cnt),
    .wb_en(s1_valid),
    .wb_addr(s1_b),
    .wb_len(rd_len),
    .wb_cnt(new_cnt),
    .clear_counts(result_load)
  );

  assign ql = (read_length == RL_SAT) ? read_length : read_length + RL_W'(1);
  assign len_ext = RL_W'(rd_len);

  always_comb begin
    new_cnt = rd_cnt;
    if (read_length < len_ext && rd_symbol != usym && rd_cnt != CNT_MAX) begin
      new_cnt = rd_cnt + CNT_W'(1);
    end
  end

  assign eligible = (9'(s1_b) < 9'(barcode_count)) && (ql >= len_ext) &&
                    (prefix_match || ql == len_ext);
  assign take = s1_valid && last_q && eligible && (!found_acc || new_cnt < bestd);
  assign out_free = !out_valid || out_ready;
  assign result_load = (state == ST_FINISH) && last_q && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_diffs <= '0;
      prefix_match <= 1'b1;
      barcode_count <= '0;
      read_length <= '0;
      s1_valid <= 1'b0;
      found_acc <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_DIFFS: max_diffs <= cfg_data;
          CFG_PREFIX_MATCH: prefix_match <= cfg_data[0];
          CFG_BARCODE_COUNT: barcode_count <= cfg_data;
          default: ;
        endcase
      end
      s1_valid <= (state == ST_SWEEP);
      if (take) begin
        found_acc <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (command == CMD_READ) begin
              state <= ST_SWEEP;
              found_acc <= 1'b0;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_SWEEP: begin
          if (sweep_b == LAST_B) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_FINISH;
        ST_FINISH: begin
          if (!last_q) begin
            read_length <= ql;
            state <= ST_IDLE;
          end else if (out_free) begin
            read_length <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_READ) begin
      usym <= up_case(symbol);
      last_q <= last;
      sweep_b <= '0;
      best <= '0;
      bestd <= '0;
    end else if (state == ST_SWEEP) begin
      sweep_b <= sweep_b + SLOT_W'(1);
    end
    s1_b <= sweep_b;
    if (take) begin
      best <= s1_b;
      bestd <= new_cnt;
    end
    if (result_load) begin
      best_slot <= 4'(best);
      min_diffs <= bestd;
      found <= found_acc;
      assigned <= found_acc && (bestd <= max_diffs);
    end
  end

  `NBHM_ASSERT_IMPL(a_ready_idle, in_ready, !s1_valid && state == ST_IDLE, "accepting with a sweep pending")
  `NBHM_ASSERT_NEXT(a_sweep_end, state == ST_SWEEP && sweep_b == LAST_B, state == ST_DRAIN && s1_valid, "sweep did not drain")
  `NBHM_ASSERT_IMPL(a_none_zero, out_valid && !found, best_slot == 4'd0 && min_diffs == 5'd0 && !assigned, "empty result not zero")
  `NBHM_ASSERT_NEXT(a_read_done, result_load, out_valid && read_length == '0 && state == ST_IDLE, "read not retired")

endmodule
